@@ design/sbeg_pkg.sv @@
// Package for the stencil bending energy gradient unit: transaction types,
// mode codes and the saturating fixed-point helpers.
// No dependencies; sbeg_calc and the top level import it.
`default_nettype none

package sbeg_pkg;

  localparam int unsigned MaxVerticesDef = 1024;
  localparam int unsigned ValW           = 32;
  localparam int unsigned GradW          = 48;
  localparam int unsigned EnergyW        = 63;
  localparam int unsigned PosEntryW      = 3 * ValW;
  localparam int unsigned GradEntryW     = 3 * GradW;

  typedef enum logic [2:0] {
    ModeLoad     = 3'd0,
    ModeInterior = 3'd1,
    ModeBoundary = 3'd2,
    ModeRead     = 3'd3,
    ModeClear    = 3'd4
  } mode_e;

  typedef struct packed {
    logic [2:0]         mode;
    logic [9:0]         center_index;
    logic [9:0]         x_front_index;
    logic [9:0]         y_front_index;
    logic [9:0]         x_back_index;
    logic [9:0]         y_back_index;
    logic signed [31:0] value_a;
    logic signed [31:0] value_b;
    logic signed [31:0] value_c;
    logic signed [31:0] value_d;
  } in_t;

  typedef struct packed {
    logic [62:0]        energy_total;
    logic signed [47:0] grad_x;
    logic signed [47:0] grad_y;
    logic signed [47:0] grad_z;
    logic               overflow;
  } out_t;

  typedef struct packed {
    logic               ovf;
    logic signed [63:0] v;
  } sat64_t;

  typedef struct packed {
    logic               ovf;
    logic signed [47:0] v;
  } sat48_t;

  // Operands for one direction and one coordinate.
  typedef struct packed {
    logic               start;
    logic signed [31:0] wf;
    logic signed [31:0] wb;
    logic signed [31:0] p0;
    logic signed [31:0] pf;
    logic signed [31:0] pb;
  } calc_req_t;

  typedef struct packed {
    logic               done;
    logic               ovf;
    logic [62:0]        sq;
    logic signed [63:0] cen;
    logic signed [63:0] nf;
    logic signed [63:0] nb;
  } calc_rsp_t;

  function automatic sat64_t sadd64(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [64:0] s;
    sat64_t r;
    s = {a[63], a} + {b[63], b};
    r.ovf = (s[64] != s[63]);
    if (!r.ovf) r.v = s[63:0];
    else if (s[64]) r.v = {1'b1, {63{1'b0}}};
    else r.v = {1'b0, {63{1'b1}}};
    return r;
  endfunction

  // Negation from zero; only the most negative value saturates.
  function automatic sat64_t sneg64(logic signed [63:0] a);
    sat64_t r;
    r.ovf = (a == {1'b1, {63{1'b0}}});
    r.v = r.ovf ? {1'b0, {63{1'b1}}} : -a;
    return r;
  endfunction

  // Q32.32 to Q16.16 with round half up.
  function automatic logic signed [48:0] to_q16(logic signed [63:0] a);
    return $signed({a[63], a[63:16]}) + $signed({48'd0, a[15]});
  endfunction

  function automatic sat48_t gadd(logic signed [47:0] g, logic signed [48:0] q);
    logic signed [49:0] s;
    sat48_t r;
    s = {{2{g[47]}}, g} + {q[48], q};
    r.ovf = !((s[49:47] == 3'b000) || (s[49:47] == 3'b111));
    if (!r.ovf) r.v = s[47:0];
    else if (s[49]) r.v = {1'b1, {47{1'b0}}};
    else r.v = {1'b0, {47{1'b1}}};
    return r;
  endfunction

  function automatic logic signed [31:0] pos_lane(logic [95:0] e, logic [1:0] k);
    logic signed [31:0] r;
    case (k)
      2'd0:    r = e[31:0];
      2'd1:    r = e[63:32];
      default: r = e[95:64];
    endcase
    return r;
  endfunction

  // Reduces a 10-bit index modulo the store depth by shifted subtraction.
  function automatic logic [15:0] idx_mod(logic [9:0] v, int unsigned m);
    int unsigned r;
    r = 32'(v);
    for (int i = 9; i >= 0; i--) begin
      if (r >= (m << i)) r = r - (m << i);
    end
    return r[15:0];
  endfunction

endpackage

`default_nettype wire

@@ design/sbeg_ram.sv @@
// Generic single-port synchronous RAM with a registered read.
// Depends on nothing.
`default_nettype none

module sbeg_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ design/sbeg_calc.sv @@
// Per-direction, per-coordinate arithmetic around one shared 32x32 multiplier.
// Uses sbeg_pkg for the request and response structs and saturating helpers.
`default_nettype none

module sbeg_calc import sbeg_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  calc_req_t req_i,
  output calc_rsp_t rsp_o
);

  localparam logic [3:0] StWbP0  = 4'd0;
  localparam logic [3:0] StWfP0  = 4'd1;
  localparam logic [3:0] StWbPb  = 4'd2;
  localparam logic [3:0] StWfPf  = 4'd3;
  localparam logic [3:0] StSum   = 4'd4;
  localparam logic [3:0] StRound = 4'd5;
  localparam logic [3:0] StSq    = 4'd6;
  localparam logic [3:0] StWbD   = 4'd7;
  localparam logic [3:0] StWfD   = 4'd8;
  localparam logic [3:0] StRf    = 4'd9;
  localparam logic [3:0] StPair  = 4'd10;
  localparam logic [3:0] StOut   = 4'd11;

  logic               busy_q;
  logic               done_q;
  logic [3:0]         step_q;
  logic               ovf_q;
  logic signed [31:0] ma;
  logic signed [31:0] mb;
  logic signed [63:0] mprod;
  logic signed [63:0] prod_q;
  logic signed [63:0] acc_q;
  logic signed [31:0] d_q;
  logic [62:0]        sq_q;
  logic signed [63:0] rb_q;
  logic signed [63:0] rf_q;
  logic signed [63:0] t_q;
  logic signed [63:0] db_q;
  logic signed [63:0] df_q;
  logic signed [63:0] cen_q;
  logic signed [63:0] nf_q;
  logic signed [63:0] nb_q;
  sat64_t             s_add;
  sat64_t             s_sub;
  sat64_t             s_t;
  sat64_t             s_db;
  sat64_t             s_df;
  sat64_t             s_cen;
  sat64_t             s_nb;
  sat64_t             s_nf;
  logic signed [48:0] q;
  logic               d_ovf;
  logic signed [31:0] d_sat;

  always_comb begin
    case (step_q)
      StWbP0:  begin ma = req_i.wb; mb = req_i.p0; end
      StWfP0:  begin ma = req_i.wf; mb = req_i.p0; end
      StWbPb:  begin ma = req_i.wb; mb = req_i.pb; end
      StWfPf:  begin ma = req_i.wf; mb = req_i.pf; end
      StSq:    begin ma = d_q;      mb = d_q;      end
      StWbD:   begin ma = req_i.wb; mb = d_q;      end
      StWfD:   begin ma = req_i.wf; mb = d_q;      end
      default: begin ma = req_i.wb; mb = req_i.p0; end
    endcase
  end

  assign mprod = ma * mb;

  // Products never reach the most negative 64-bit value, so plain negation is exact.
  assign s_add = sadd64(acc_q, prod_q);
  assign s_sub = sadd64(acc_q, -prod_q);
  assign q     = to_q16(acc_q);
  assign d_ovf = !((q[48:31] == '0) || (q[48:31] == '1));
  assign d_sat = d_ovf ? (q[48] ? {1'b1, {31{1'b0}}} : {1'b0, {31{1'b1}}}) : q[31:0];
  assign s_t   = sadd64(rb_q, rf_q);
  assign s_db  = sadd64(rb_q, rb_q);
  assign s_df  = sadd64(rf_q, rf_q);
  assign s_cen = sadd64(t_q, t_q);
  assign s_nb  = sneg64(db_q);
  assign s_nf  = sneg64(df_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= StWbP0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= StWbP0;
      end else if (busy_q) begin
        if (step_q == StOut) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        step_q <= step_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      ovf_q <= 1'b0;
    end else if (busy_q) begin
      prod_q <= mprod;
      case (step_q) inside
        StWfP0: acc_q <= prod_q;
        StWbPb: begin
          acc_q <= s_add.v;
          ovf_q <= ovf_q | s_add.ovf;
        end
        StWfPf, StSum: begin
          acc_q <= s_sub.v;
          ovf_q <= ovf_q | s_sub.ovf;
        end
        StRound: begin
          d_q   <= d_sat;
          ovf_q <= ovf_q | d_ovf;
        end
        StWbD: sq_q <= prod_q[62:0];
        StWfD: rb_q <= prod_q;
        StRf:  rf_q <= prod_q;
        StPair: begin
          t_q   <= s_t.v;
          db_q  <= s_db.v;
          df_q  <= s_df.v;
          ovf_q <= ovf_q | s_t.ovf | s_db.ovf | s_df.ovf;
        end
        StOut: begin
          cen_q <= s_cen.v;
          nb_q  <= s_nb.v;
          nf_q  <= s_nf.v;
          ovf_q <= ovf_q | s_cen.ovf | s_nb.ovf | s_nf.ovf;
        end
        default: ;
      endcase
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.ovf  = ovf_q;
  assign rsp_o.sq   = sq_q;
  assign rsp_o.cen  = cen_q;
  assign rsp_o.nf   = nf_q;
  assign rsp_o.nb   = nb_q;

endmodule

`default_nettype wire

@@ design/stencil_bending_energy_gradient_unit.sv @@
// Top level of the stencil bending energy gradient unit: sequencer, position and
// gradient memories, energy total. Uses sbeg_pkg, sbeg_ram and sbeg_calc.
//
//   Channel | Direction | Handshake             | Payload
//   input   | in        | in_valid_i/in_stall_o | in_data_i (in_t)
//   output  | out       | out_valid_o/out_stall_i | out_data_o (out_t)
//
// One transaction at a time. An interior (boundary) stencil does five (three) position
// reads, six (three) arithmetic jobs on the one shared multiplier, then a read and a
// write per gradient entry on the single-port memory. Reset clears the control state,
// the energy total and the overflow flag; the memories hold garbage until written. A
// stalled output holds its result while the next transaction is taken; that
// transaction waits at its end for the output register.
`default_nettype none

module stencil_bending_energy_gradient_unit import sbeg_pkg::*; #(
  parameter int unsigned MAX_VERTICES = MaxVerticesDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  localparam int unsigned AddrW = $clog2(MAX_VERTICES);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LOAD = 4'd1;
  localparam logic [3:0] S_GRD  = 4'd2;
  localparam logic [3:0] S_GRW  = 4'd3;
  localparam logic [3:0] S_PRD  = 4'd4;
  localparam logic [3:0] S_CGO  = 4'd5;
  localparam logic [3:0] S_CWT  = 4'd6;
  localparam logic [3:0] S_SRD  = 4'd7;
  localparam logic [3:0] S_SWR  = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;

  logic [3:0]            state_q;
  logic                  out_valid_q;
  out_t                  out_q;
  logic [EnergyW-1:0]    energy_q;
  logic                  flag_q;
  logic [2:0]            rc_q;
  logic [2:0]            sc_q;
  logic                  dir_q;
  logic [1:0]            k_q;

  logic [2:0]            mode_q;
  logic [AddrW-1:0]      idx_c_q;
  logic [AddrW-1:0]      idx_xf_q;
  logic [AddrW-1:0]      idx_yf_q;
  logic [AddrW-1:0]      idx_xb_q;
  logic [AddrW-1:0]      idx_yb_q;
  logic signed [31:0]    va_q;
  logic signed [31:0]    vb_q;
  logic signed [31:0]    vc_q;
  logic signed [31:0]    vd_q;
  logic [PosEntryW-1:0]  pos_c_q;
  logic [PosEntryW-1:0]  pos_xf_q;
  logic [PosEntryW-1:0]  pos_xb_q;
  logic [PosEntryW-1:0]  pos_yf_q;
  logic [PosEntryW-1:0]  pos_yb_q;
  logic [GradEntryW-1:0] res_g_q;
  logic signed [63:0]    cen_q  [3];
  logic signed [63:0]    nb_x_q [3];
  logic signed [63:0]    nf_x_q [3];
  logic signed [63:0]    nb_y_q [3];
  logic signed [63:0]    nf_y_q [3];

  logic [15:0]           red_c;
  logic [15:0]           red_xf;
  logic [15:0]           red_yf;
  logic [15:0]           red_xb;
  logic [15:0]           red_yb;
  logic                  bnd;
  logic [2:0]            rd_n;
  logic [2:0]            sc_n;
  logic [AddrW-1:0]      rd_addr;
  logic [AddrW-1:0]      sc_addr;
  logic signed [63:0]    sc_val [3];
  sat48_t                ga     [3];
  logic                  ga_ovf;
  logic                  in_acc;
  logic                  out_load;
  logic [63:0]           e_sum;
  sat64_t                s_comb;

  logic                  pos_en;
  logic                  pos_we;
  logic [AddrW-1:0]      pos_addr;
  logic [PosEntryW-1:0]  pos_wdata;
  logic [PosEntryW-1:0]  pos_rdata;
  logic                  grad_en;
  logic                  grad_we;
  logic [AddrW-1:0]      grad_addr;
  logic [GradEntryW-1:0] grad_wdata;
  logic [GradEntryW-1:0] grad_rdata;

  calc_req_t             calc_req;
  calc_rsp_t             calc_rsp;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == S_FIN) && (!out_valid_q || !out_stall_i);

  assign red_c  = idx_mod(in_data_i.center_index, MAX_VERTICES);
  assign red_xf = idx_mod(in_data_i.x_front_index, MAX_VERTICES);
  assign red_yf = idx_mod(in_data_i.y_front_index, MAX_VERTICES);
  assign red_xb = idx_mod(in_data_i.x_back_index, MAX_VERTICES);
  assign red_yb = idx_mod(in_data_i.y_back_index, MAX_VERTICES);

  assign bnd  = (mode_q == ModeBoundary);
  assign rd_n = bnd ? 3'd3 : 3'd5;
  assign sc_n = bnd ? 3'd3 : 3'd5;

  // Position reads go centre, x front, x back, y front, y back.
  always_comb begin
    case (rc_q)
      3'd0:    rd_addr = idx_c_q;
      3'd1:    rd_addr = idx_xf_q;
      3'd2:    rd_addr = idx_xb_q;
      3'd3:    rd_addr = idx_yf_q;
      default: rd_addr = idx_yb_q;
    endcase
  end

  // Scatter order: centre, x back, x front, y back, y front.
  always_comb begin
    case (sc_q)
      3'd0:    sc_addr = idx_c_q;
      3'd1:    sc_addr = idx_xb_q;
      3'd2:    sc_addr = idx_xf_q;
      3'd3:    sc_addr = idx_yb_q;
      default: sc_addr = idx_yf_q;
    endcase
    for (int k = 0; k < 3; k++) begin
      case (sc_q)
        3'd0:    sc_val[k] = cen_q[k];
        3'd1:    sc_val[k] = nb_x_q[k];
        3'd2:    sc_val[k] = nf_x_q[k];
        3'd3:    sc_val[k] = nb_y_q[k];
        default: sc_val[k] = nf_y_q[k];
      endcase
      ga[k] = gadd(grad_rdata[k*GradW +: GradW], to_q16(sc_val[k]));
    end
  end

  assign ga_ovf = ga[0].ovf | ga[1].ovf | ga[2].ovf;

  always_comb begin
    pos_en     = 1'b0;
    pos_we     = 1'b0;
    pos_addr   = idx_c_q;
    pos_wdata  = {vc_q, vb_q, va_q};
    grad_en    = 1'b0;
    grad_we    = 1'b0;
    grad_addr  = idx_c_q;
    grad_wdata = '0;
    unique case (state_q)
      S_LOAD: begin
        pos_en  = 1'b1;
        pos_we  = 1'b1;
        grad_en = 1'b1;
        grad_we = 1'b1;
      end
      S_GRD: grad_en = 1'b1;
      S_PRD: begin
        pos_en   = (rc_q < rd_n);
        pos_addr = rd_addr;
      end
      S_SRD: begin
        grad_en   = 1'b1;
        grad_addr = sc_addr;
      end
      S_SWR: begin
        grad_en    = 1'b1;
        grad_we    = 1'b1;
        grad_addr  = sc_addr;
        grad_wdata = {ga[2].v, ga[1].v, ga[0].v};
      end
      default: ;
    endcase
  end

  sbeg_ram #(
    .WIDTH (PosEntryW),
    .DEPTH (MAX_VERTICES)
  ) u_pos_ram (
    .clk_i   (clk_i),
    .en_i    (pos_en),
    .we_i    (pos_we),
    .addr_i  (pos_addr),
    .wdata_i (pos_wdata),
    .rdata_o (pos_rdata)
  );

  sbeg_ram #(
    .WIDTH (GradEntryW),
    .DEPTH (MAX_VERTICES)
  ) u_grad_ram (
    .clk_i   (clk_i),
    .en_i    (grad_en),
    .we_i    (grad_we),
    .addr_i  (grad_addr),
    .wdata_i (grad_wdata),
    .rdata_o (grad_rdata)
  );

  assign calc_req.start = (state_q == S_CGO);
  assign calc_req.wf    = dir_q ? vc_q : va_q;
  assign calc_req.wb    = dir_q ? vd_q : vb_q;
  assign calc_req.p0    = pos_lane(pos_c_q, k_q);
  assign calc_req.pf    = pos_lane(dir_q ? pos_yf_q : pos_xf_q, k_q);
  assign calc_req.pb    = pos_lane(dir_q ? pos_yb_q : pos_xb_q, k_q);

  sbeg_calc u_calc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (calc_req),
    .rsp_o  (calc_rsp)
  );

  assign e_sum  = {1'b0, energy_q} + {1'b0, calc_rsp.sq};
  assign s_comb = sadd64(cen_q[k_q], calc_rsp.cen);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      energy_q    <= '0;
      flag_q      <= 1'b0;
      rc_q        <= '0;
      sc_q        <= '0;
      dir_q       <= 1'b0;
      k_q         <= '0;
    end else begin
      if (out_load) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            rc_q  <= '0;
            sc_q  <= '0;
            dir_q <= 1'b0;
            k_q   <= '0;
            unique case (in_data_i.mode) inside
              ModeLoad:                   state_q <= S_LOAD;
              ModeInterior, ModeBoundary: state_q <= S_PRD;
              ModeRead:                   state_q <= S_GRD;
              ModeClear: begin
                energy_q <= '0;
                state_q  <= S_FIN;
              end
              default:                    state_q <= S_FIN;
            endcase
          end
        end
        S_LOAD: state_q <= S_FIN;
        S_GRD:  state_q <= S_GRW;
        S_GRW:  state_q <= S_FIN;
        S_PRD: begin
          rc_q <= rc_q + 3'd1;
          if (rc_q == rd_n) state_q <= S_CGO;
        end
        S_CGO: state_q <= S_CWT;
        S_CWT: begin
          if (calc_rsp.done) begin
            energy_q <= e_sum[63] ? {EnergyW{1'b1}} : e_sum[62:0];
            flag_q   <= flag_q | calc_rsp.ovf | e_sum[63] | (dir_q & s_comb.ovf);
            if (k_q == 2'd2) begin
              k_q <= '0;
              if (dir_q || bnd) begin
                state_q <= S_SRD;
              end else begin
                dir_q   <= 1'b1;
                state_q <= S_CGO;
              end
            end else begin
              k_q     <= k_q + 2'd1;
              state_q <= S_CGO;
            end
          end
        end
        S_SRD: state_q <= S_SWR;
        S_SWR: begin
          flag_q <= flag_q | ga_ovf;
          sc_q   <= sc_q + 3'd1;
          if (sc_q == sc_n - 3'd1) state_q <= S_FIN;
          else state_q <= S_SRD;
        end
        S_FIN: begin
          if (out_load) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mode_q   <= in_data_i.mode;
      idx_c_q  <= red_c[AddrW-1:0];
      idx_xf_q <= red_xf[AddrW-1:0];
      idx_yf_q <= red_yf[AddrW-1:0];
      idx_xb_q <= red_xb[AddrW-1:0];
      idx_yb_q <= red_yb[AddrW-1:0];
      va_q     <= in_data_i.value_a;
      vb_q     <= in_data_i.value_b;
      vc_q     <= in_data_i.value_c;
      vd_q     <= in_data_i.value_d;
    end
    // Read data arrives in the cycle after its address, so the counter is one ahead.
    if ((state_q == S_PRD) && (rc_q != 3'd0)) begin
      case (rc_q)
        3'd1:    pos_c_q  <= pos_rdata;
        3'd2:    pos_xf_q <= pos_rdata;
        3'd3:    pos_xb_q <= pos_rdata;
        3'd4:    pos_yf_q <= pos_rdata;
        default: pos_yb_q <= pos_rdata;
      endcase
    end
    if (state_q == S_GRW) res_g_q <= grad_rdata;
    if ((state_q == S_CWT) && calc_rsp.done) begin
      if (dir_q) begin
        cen_q[k_q]  <= s_comb.v;
        nb_y_q[k_q] <= calc_rsp.nb;
        nf_y_q[k_q] <= calc_rsp.nf;
      end else begin
        cen_q[k_q]  <= calc_rsp.cen;
        nb_x_q[k_q] <= calc_rsp.nb;
        nf_x_q[k_q] <= calc_rsp.nf;
      end
    end
    if (out_load) begin
      out_q.energy_total <= energy_q;
      out_q.overflow     <= flag_q;
      if (mode_q == ModeRead) begin
        out_q.grad_x <= res_g_q[GradW-1:0];
        out_q.grad_y <= res_g_q[2*GradW-1:GradW];
        out_q.grad_z <= res_g_q[3*GradW-1:2*GradW];
      end else begin
        out_q.grad_x <= '0;
        out_q.grad_y <= '0;
        out_q.grad_z <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) flag_q |=> flag_q)
    else $error("overflow flag dropped without reset");

  assert property (@(posedge clk_i) disable iff (!rst_ni) in_acc |=> (state_q != S_IDLE))
    else $error("accepted transaction did not start work");

  assert property (@(posedge clk_i) disable iff (!rst_ni) (state_q == S_SWR) |-> (sc_q < sc_n))
    else $error("scatter counter ran past the stencil");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_load && (mode_q != ModeRead) |=>
      (out_data_o.grad_x == '0) && (out_data_o.grad_y == '0) && (out_data_o.grad_z == '0))
    else $error("gradient shown outside read mode");

endmodule

`default_nettype wire

@@ sim/stencil_bending_energy_gradient_unit_tb.sv @@
// Testbench for stencil_bending_energy_gradient_unit: directed and random stencil,
// load, read and clear transactions, checked against a fixed-point predictor.
// Depends on sbeg_pkg and the design top level only.
`timescale 1ns / 1ps

module stencil_bending_energy_gradient_unit_tb;
  import sbeg_pkg::*;

  localparam int      NumVert   = 1024;
  localparam longint  S64Max    = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint  S64Min    = -S64Max - 1;
  localparam longint  G48Max    = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint  G48Min    = -G48Max - 1;
  localparam int      StallLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  stencil_bending_energy_gradient_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always #6 clk_i = ~clk_i;

  // Shadow copy of the block state.
  longint posv[3][NumVert];
  longint gradv[3][NumVert];
  longint energy_acc;
  bit     sat_seen;
  bit     loaded[NumVert];
  int     loaded_list[$];

  out_t   expected_q[$];
  int     err_count;
  int     mode_cnt[8];
  int     rx_hold;
  int     hold_req = 0;
  int     hold_seen = 0;
  bit     rx_quiet;
  bit     tx_quiet;
  int     idle_cycles;

  function automatic longint clamp64(logic signed [64:0] s);
    if (s > S64Max) begin
      sat_seen = 1'b1;
      return S64Max;
    end
    if (s < S64Min) begin
      sat_seen = 1'b1;
      return S64Min;
    end
    return longint'(s);
  endfunction

  function automatic longint sat_add(longint a, longint b);
    logic signed [64:0] s;
    s = a;
    s = s + b;
    return clamp64(s);
  endfunction

  function automatic longint sat_sub(longint a, longint b);
    logic signed [64:0] s;
    s = a;
    s = s - b;
    return clamp64(s);
  endfunction

  // Q32.32 to Q16.16, rounding half up.
  function automatic longint to_fix16(longint t);
    return (t >>> 16) + longint'(t[15]);
  endfunction

  function automatic void grad_accum(int k, int idx, longint v);
    longint s;
    s = gradv[k][idx] + v;
    if (s > G48Max) begin
      s = G48Max;
      sat_seen = 1'b1;
    end
    if (s < G48Min) begin
      s = G48Min;
      sat_seen = 1'b1;
    end
    gradv[k][idx] = s;
  endfunction

  // Energy and Q32.32 gradient terms of one axis direction.
  function automatic void axis_terms(int c, int f, int b, longint wf, longint wb,
                                     output longint cen[3], output longint nf[3],
                                     output longint nb[3]);
    longint t, d, sq;
    for (int k = 0; k < 3; k++) begin
      t = sat_add(wb * posv[k][c], wf * posv[k][c]);
      t = sat_sub(t, wb * posv[k][b]);
      t = sat_sub(t, wf * posv[k][f]);
      d = to_fix16(t);
      if (d > 64'sd2147483647) begin
        d = 64'sd2147483647;
        sat_seen = 1'b1;
      end
      if (d < -64'sd2147483648) begin
        d = -64'sd2147483648;
        sat_seen = 1'b1;
      end
      sq = d * d;
      if (sq > S64Max - energy_acc) begin
        energy_acc = S64Max;
        sat_seen = 1'b1;
      end else begin
        energy_acc = energy_acc + sq;
      end
      t = sat_add(wb * d, wf * d);
      cen[k] = sat_add(t, t);
      nf[k] = sat_sub(0, sat_add(wf * d, wf * d));
      nb[k] = sat_sub(0, sat_add(wb * d, wb * d));
    end
  endfunction

  function automatic out_t predict_result(in_t c);
    out_t   r;
    int     ci, xf, yf, xb, yb;
    longint cx[3], nxf[3], nxb[3], cy[3], nyf[3], nyb[3];
    ci = int'(c.center_index);
    xf = int'(c.x_front_index);
    yf = int'(c.y_front_index);
    xb = int'(c.x_back_index);
    yb = int'(c.y_back_index);
    r = '0;
    case (c.mode)
      ModeLoad: begin
        posv[0][ci] = longint'(c.value_a);
        posv[1][ci] = longint'(c.value_b);
        posv[2][ci] = longint'(c.value_c);
        for (int k = 0; k < 3; k++) gradv[k][ci] = 0;
      end
      ModeInterior: begin
        axis_terms(ci, xf, xb, longint'(c.value_a), longint'(c.value_b), cx, nxf, nxb);
        axis_terms(ci, yf, yb, longint'(c.value_c), longint'(c.value_d), cy, nyf, nyb);
        for (int k = 0; k < 3; k++) cx[k] = sat_add(cx[k], cy[k]);
        for (int k = 0; k < 3; k++) grad_accum(k, ci, to_fix16(cx[k]));
        for (int k = 0; k < 3; k++) grad_accum(k, xb, to_fix16(nxb[k]));
        for (int k = 0; k < 3; k++) grad_accum(k, xf, to_fix16(nxf[k]));
        for (int k = 0; k < 3; k++) grad_accum(k, yb, to_fix16(nyb[k]));
        for (int k = 0; k < 3; k++) grad_accum(k, yf, to_fix16(nyf[k]));
      end
      ModeBoundary: begin
        axis_terms(ci, xf, xb, longint'(c.value_a), longint'(c.value_b), cx, nxf, nxb);
        for (int k = 0; k < 3; k++) grad_accum(k, ci, to_fix16(cx[k]));
        for (int k = 0; k < 3; k++) grad_accum(k, xb, to_fix16(nxb[k]));
        for (int k = 0; k < 3; k++) grad_accum(k, xf, to_fix16(nxf[k]));
      end
      ModeRead: begin
        r.grad_x = gradv[0][ci][47:0];
        r.grad_y = gradv[1][ci][47:0];
        r.grad_z = gradv[2][ci][47:0];
      end
      ModeClear: energy_acc = 0;
      default: ;
    endcase
    r.energy_total = energy_acc[62:0];
    r.overflow = sat_seen;
    return r;
  endfunction

  task automatic report_mismatch(string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    err_count++;
  endtask

  function automatic int pick_gap();
    int r;
    if (tx_quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Offers one transaction and returns at the edge where it is taken.
  task automatic send_cmd(in_t c);
    int  gap;
    bit  stalled;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= c;
    do begin
      @(negedge clk_i);
      stalled = in_stall;
      @(posedge clk_i);
    end while (stalled);
    expected_q.push_back(predict_result(c));
    mode_cnt[c.mode]++;
    if (c.mode == ModeLoad && !loaded[c.center_index]) begin
      loaded[c.center_index] = 1'b1;
      loaded_list.push_back(int'(c.center_index));
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  // Output checker and watchdog, both at the falling edge where handshakes are stable.
  always @(negedge clk_i) begin
    out_t e;
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("Timeout: no transaction for %0d cycles", StallLimit);
        $display("Some tests failed");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result with no transaction pending");
        end else begin
          e = expected_q.pop_front();
          if (out_data.energy_total !== e.energy_total)
            report_mismatch($sformatf("energy_total %h expected %h",
                                      out_data.energy_total, e.energy_total));
          if (out_data.grad_x !== e.grad_x)
            report_mismatch($sformatf("grad_x %h expected %h", out_data.grad_x, e.grad_x));
          if (out_data.grad_y !== e.grad_y)
            report_mismatch($sformatf("grad_y %h expected %h", out_data.grad_y, e.grad_y));
          if (out_data.grad_z !== e.grad_z)
            report_mismatch($sformatf("grad_z %h expected %h", out_data.grad_z, e.grad_z));
          if (out_data.overflow !== e.overflow)
            report_mismatch($sformatf("overflow %b expected %b",
                                      out_data.overflow, e.overflow));
        end
      end
    end
  end

  // Receiver back-pressure: short random stalls, occasional long ones, forced holds.
  // A forced hold is requested by bumping hold_req; only this process counts it down.
  always @(posedge clk_i) begin
    int r;
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      out_stall <= 1'b1;
      rx_hold <= 600;
    end else if (rx_hold > 0) begin
      out_stall <= 1'b1;
      rx_hold <= rx_hold - 1;
    end else if (rx_quiet) begin
      out_stall <= 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 60) out_stall <= 1'b0;
      else if (r < 97) begin
        out_stall <= 1'b1;
        rx_hold <= $urandom_range(0, 3);
      end else begin
        out_stall <= 1'b1;
        rx_hold <= $urandom_range(20, 200);
      end
    end
  end

  function automatic logic signed [31:0] rand_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return $urandom();
    if (r < 11) begin
      case ($urandom_range(0, 3))
        0: return 32'sh7FFF_FFFF;
        1: return 32'sh8000_0000;
        2: return 32'sh0000_8000;
        default: return 32'sh0000_0000;
      endcase
    end
    return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
  endfunction

  function automatic int rand_vertex();
    return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
  endfunction

  function automatic in_t make_cmd(mode_e m, int ci, int xf, int yf, int xb, int yb);
    in_t c;
    c.mode = m;
    c.center_index = 10'(ci);
    c.x_front_index = 10'(xf);
    c.y_front_index = 10'(yf);
    c.x_back_index = 10'(xb);
    c.y_back_index = 10'(yb);
    c.value_a = rand_value();
    c.value_b = rand_value();
    c.value_c = rand_value();
    c.value_d = rand_value();
    return c;
  endfunction

  // Random transaction, mostly stencils on loaded vertices.
  function automatic in_t rand_cmd();
    in_t c;
    int  r;
    r = $urandom_range(0, 99);
    c = make_cmd(ModeInterior, rand_vertex(), rand_vertex(), rand_vertex(),
                 rand_vertex(), rand_vertex());
    if (r < 12) begin
      c.mode = ModeLoad;
      c.center_index = 10'($urandom_range(0, NumVert - 1));
    end else if (r < 50) begin
      c.mode = ModeInterior;
    end else if (r < 70) begin
      c.mode = ModeBoundary;
      c.y_front_index = 10'($urandom());
      c.y_back_index = 10'($urandom());
    end else if (r < 92) begin
      c.mode = ModeRead;
      c.x_front_index = 10'($urandom());
      c.y_back_index = 10'($urandom());
    end else if (r < 96) begin
      c = make_cmd(ModeClear, $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
    end else begin
      c = make_cmd(ModeClear, $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
      c.mode = 3'($urandom_range(5, 7));
    end
    return c;
  endfunction

  task automatic test_directed();
    in_t c;
    int  v[7] = '{0, 1023, 512, 341, 682, 7, 1016};
    foreach (v[i]) begin
      c = make_cmd(ModeLoad, v[i], 0, 0, 0, 0);
      c.value_a = $signed(i * 32'h0001_0000);
      c.value_b = -$signed(i * 32'h0000_8000);
      c.value_c = 32'sh0000_4000 * i;
      send_cmd(c);
    end
    c = make_cmd(ModeInterior, 512, 341, 682, 0, 1023);
    c.value_a = 32'sh0001_0000; c.value_b = 32'sh0001_0000;
    c.value_c = 32'sh0000_8000; c.value_d = 32'sh0002_0000;
    send_cmd(c);
    c = make_cmd(ModeBoundary, 7, 1016, 555, 0, 999);
    c.value_a = 32'sh0000_C000; c.value_b = 32'sh0001_8000;
    send_cmd(c);
    // Every neighbour the same vertex as the centre: all terms pile onto one entry.
    c = make_cmd(ModeInterior, 341, 341, 341, 341, 341);
    send_cmd(c);
    foreach (v[i]) if (i < 4) send_cmd(make_cmd(ModeRead, v[i], 0, 1023, 0, 1023));
    send_cmd(make_cmd(ModeClear, 1023, 1023, 1023, 1023, 1023));
    for (int m = 5; m < 8; m++) begin
      c = make_cmd(ModeClear, 0, 0, 0, 0, 0);
      c.mode = 3'(m);
      send_cmd(c);
    end
    // Extreme positions and weights drive the arithmetic into saturation.
    c = make_cmd(ModeLoad, 1023, 0, 0, 0, 0);
    c.value_a = 32'sh7FFF_FFFF; c.value_b = 32'sh8000_0000; c.value_c = 32'sh7FFF_FFFF;
    send_cmd(c);
    c = make_cmd(ModeInterior, 1023, 0, 0, 512, 512);
    c.value_a = 32'sh8000_0000; c.value_b = 32'sh8000_0000;
    c.value_c = 32'sh7FFF_FFFF; c.value_d = 32'sh8000_0000;
    send_cmd(c);
    send_cmd(make_cmd(ModeRead, 1023, 0, 0, 0, 0));
    send_cmd(make_cmd(ModeRead, 0, 0, 0, 0, 0));
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) send_cmd(rand_cmd());
  endtask

  task automatic test_output_hold();
    wait_drained();
    hold_req++;
    tx_quiet = 1'b1;
    test_random(8);
    tx_quiet = 1'b0;
  endtask

  task automatic test_drained_sender();
    for (int i = 0; i < 40; i++) begin
      wait_drained();
      send_cmd(rand_cmd());
    end
  endtask

  task automatic test_no_stall();
    rx_quiet = 1'b1;
    tx_quiet = 1'b1;
    test_random(150);
    rx_quiet = 1'b0;
    tx_quiet = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(700);
    test_output_hold();
    test_drained_sender();
    test_no_stall();
    test_random(720);
    wait_drained();
    repeat (200) @(posedge clk_i);
    $display("Covered %0d loads, %0d interior and %0d boundary stencils, %0d reads,",
             mode_cnt[ModeLoad], mode_cnt[ModeInterior], mode_cnt[ModeBoundary],
             mode_cnt[ModeRead]);
    $display("%0d energy clears and %0d unused-mode transactions; %0d mismatches.",
             mode_cnt[ModeClear], mode_cnt[5] + mode_cnt[6] + mode_cnt[7], err_count);
    if (err_count == 0 && expected_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
